[sv/esc_pkg.sv]
package esc_pkg;

	// characters with a meaning of their own
	localparam logic [7:0] SYM_END   = 8'h00;
	localparam logic [7:0] SYM_OPEN  = 8'h28; // (
	localparam logic [7:0] SYM_CLOSE = 8'h29; // )
	localparam logic [7:0] SYM_X     = 8'h78; // x
	localparam logic [7:0] SYM_PLUS  = 8'h2b; // +
	localparam logic [7:0] SYM_MINUS = 8'h2d; // -
	localparam logic [7:0] SYM_MUL   = 8'h2a; // *
	localparam logic [7:0] SYM_DIV   = 8'h2f; // /
	localparam logic [7:0] SYM_ZERO  = 8'h30; // 0
	localparam logic [7:0] SYM_NINE  = 8'h39; // 9
	localparam logic [7:0] SYM_PI    = 8'h50; // P

	// function names, first character in the top byte
	localparam logic [15:0] NAME_LN   = "ln";
	localparam logic [31:0] NAME_SQRT = "sqrt";
	localparam logic [23:0] NAME_SIN  = "sin";
	localparam logic [23:0] NAME_COS  = "cos";
	localparam logic [23:0] NAME_TAN  = "tan";
	localparam logic [23:0] NAME_CTG  = "ctg";

	localparam int WORD_CHARS = 4;
	localparam logic [2:0] WORD_LEN_MAX = 3'd5; // one past the buffer: too long
	localparam int BAL_W = 10;

	typedef struct packed {
		logic [WORD_CHARS-1:0][7:0] chars;
		logic [2:0]                 len;
	} word_t;

endpackage

[sv/expression_syntax_checker.sv]
// channel | dir | payload (lowest bit up)                              | request
// s       | in  | tdata[7:0] symbol                                    | one character
// m       | out | tdata[0] expression_valid, tdata[9:1] length, pad 0  | one verdict
//
// one character per cycle unless a terminator stalls: a request enters the input
// register, and the checker state updates from it when it advances; a terminator
// passes the input register and then loads the verdict register
// arst_n clears the checker state, the input stage and the verdict register
// a waiting verdict stalls only a following terminator; other characters keep
// flowing, and a stalled input stage drops s_tready
module expression_syntax_checker #(
	parameter int MAX_LEN = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // symbol
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // expression_valid, expression_length[8:0], zero fill
);

	// length counter holds 0 .. MAX_LEN
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam logic [LEN_W-1:0] LEN_SAT  = LEN_W'(MAX_LEN);
	localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(MAX_LEN - 1);

	// input stage
	logic       valid_s1;
	logic [7:0] symbol_s1;

	// checker state
	logic                      in_word_q;
	esc_pkg::word_t            word_q;
	logic                      after_open_q;
	logic [esc_pkg::BAL_W-1:0] bal_q;
	logic [LEN_W-1:0]          len_q;
	logic                      ok_q;

	// verdict register
	logic       res_valid_q;
	logic [8:0] res_len_q;

	logic is_end, advance, word_match, plain, word_ok, verdict;

	// characters that pass through unchanged
	function automatic logic is_plain(input logic [7:0] c);
		is_plain = (c == esc_pkg::SYM_X) || (c == esc_pkg::SYM_PLUS) ||
			(c == esc_pkg::SYM_MINUS) || (c == esc_pkg::SYM_MUL) ||
			(c == esc_pkg::SYM_DIV) || (c == esc_pkg::SYM_PI) ||
			((c >= esc_pkg::SYM_ZERO) && (c <= esc_pkg::SYM_NINE));
	endfunction

	esc_word_match u_match (
		.word  (word_q),
		.match (word_match)
	);

	assign is_end  = (symbol_s1 == esc_pkg::SYM_END);
	// a terminator needs the verdict register free or draining
	assign advance = valid_s1 && (!is_end || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign plain   = is_plain(symbol_s1);
	// an open word closes here on '(' or the terminator
	assign word_ok = !in_word_q || word_match;
	assign verdict = ok_q && word_ok && !after_open_q && (bal_q == '0) &&
		(len_q != '0) && (len_q <= LEN_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			symbol_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q    <= 1'b0;
			word_q.len   <= 3'd0;
			after_open_q <= 1'b0;
			bal_q        <= '0;
			len_q        <= '0;
			ok_q         <= 1'b1;
		end else if (advance) begin
			if (is_end) begin
				// verdict taken, start a fresh expression
				in_word_q    <= 1'b0;
				word_q.len   <= 3'd0;
				after_open_q <= 1'b0;
				bal_q        <= '0;
				len_q        <= '0;
				ok_q         <= 1'b1;
			end else begin
				if (len_q < LEN_SAT) begin
					len_q <= len_q + LEN_W'(1);
				end
				after_open_q <= (symbol_s1 == esc_pkg::SYM_OPEN);
				priority if (symbol_s1 == esc_pkg::SYM_OPEN) begin
					// empty brackets check is moot here, the '(' just opens
					ok_q       <= ok_q && word_ok;
					in_word_q  <= 1'b0;
					word_q.len <= 3'd0;
					bal_q      <= bal_q + esc_pkg::BAL_W'(1);
				end else if (in_word_q || !plain && symbol_s1 != esc_pkg::SYM_CLOSE) begin
					// collect into the word, ')' included once inside one
					ok_q      <= ok_q && !(after_open_q && symbol_s1 == esc_pkg::SYM_CLOSE);
					in_word_q <= 1'b1;
					if (word_q.len < 3'(esc_pkg::WORD_CHARS)) begin
						word_q.chars[word_q.len[1:0]] <= symbol_s1;
					end
					if (word_q.len < esc_pkg::WORD_LEN_MAX) begin
						word_q.len <= word_q.len + 3'd1;
					end
				end else if (symbol_s1 == esc_pkg::SYM_CLOSE) begin
					// "()" is an error
					ok_q  <= ok_q && !after_open_q;
					bal_q <= bal_q - esc_pkg::BAL_W'(1);
				end else begin
					ok_q <= ok_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && is_end) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	logic res_ok_q;

	always_ff @(posedge clk) begin
		if (advance && is_end) begin
			res_ok_q  <= verdict;
			res_len_q <= 9'(len_q);
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {6'd0, res_len_q, res_ok_q};

endmodule

[sv/esc_word_match.sv]
module esc_word_match (
	input  esc_pkg::word_t word,
	output logic           match
);

	logic [31:0] c4;

	assign c4 = {word.chars[0], word.chars[1], word.chars[2], word.chars[3]};

	always_comb begin
		match = 1'b0;
		unique case (word.len)
			3'd2: match = (c4[31:16] == esc_pkg::NAME_LN);
			3'd3: match = (c4[31:8] == esc_pkg::NAME_SIN) || (c4[31:8] == esc_pkg::NAME_COS) ||
				(c4[31:8] == esc_pkg::NAME_TAN) || (c4[31:8] == esc_pkg::NAME_CTG);
			3'd4: match = (c4 == esc_pkg::NAME_SQRT);
			default: match = 1'b0;
		endcase
	end

endmodule
